/* rtl/core/hbf2d_pkg.sv */
// Shared types and constants for the 2D equal-width histogram bin filler.
package hbf2d_pkg;

    localparam int MAX_BINS    = 62;
    localparam int COUNT_BITS  = 32;
    localparam int ADDR_W      = 12;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int BIN_W       = 6;
    localparam int SLOT_W      = BIN_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int DIVD_W      = SAMPLE_W + BIN_W;
    localparam int TOTAL_W     = 32;
    localparam int PADDR_W     = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_X_MIN  = 3'd1;
    localparam logic [2:0] REG_X_MAX  = 3'd2;
    localparam logic [2:0] REG_X_BINS = 3'd3;
    localparam logic [2:0] REG_Y_MIN  = 3'd4;
    localparam logic [2:0] REG_Y_MAX  = 3'd5;
    localparam logic [2:0] REG_Y_BINS = 3'd6;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic [ADDR_W-1:0]          read_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  slot_address;
        logic [31:0]        slot_count;
        logic [TOTAL_W-1:0] total_entries;
        logic               count_saturated;
    } t_out_item;

    // bins register of 0 acts as 1, above MAX_BINS acts as MAX_BINS
    function automatic logic [BIN_W-1:0] eff_bins(input logic [BIN_W-1:0] b);
        logic [BIN_W-1:0] r;
        r = b;
        if (b == '0) begin
            r = BIN_W'(1);
        end else if (b > BIN_W'(MAX_BINS)) begin
            r = BIN_W'(MAX_BINS);
        end
        return r;
    endfunction

endpackage

/* rtl/core/histogram_bin_filler_2d.sv */
// Top level: 2D equal-width histogram filler with count store and APB config port.
// A read goes idle, read, update; a fill goes compare, multiply, divide and save per axis,
// then address (2D only), read, update; an out-of-range or low-edge sample skips the divide.
// One item at a time, the next taken once the last result is registered; 6-step divider sets fill time.
// After reset a clearing pass zeroes the 4096-entry store, not ready meanwhile.
// Config regs reset to their defaults; reset is synchronous, active low.
module histogram_bin_filler_2d
    import hbf2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // fill / read item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    // APB-style config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CMP, S_MUL, S_DIV, S_SAVE, S_ADDR, S_READ, S_UPD
    } t_state;

    // ---------------- configuration registers ----------------
    logic                       r_two_axis;
    logic signed [SAMPLE_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [BIN_W-1:0]           r_x_bins, r_y_bins;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_axis <= 1'b0;
            r_x_min    <= '0;
            r_x_max    <= SAMPLE_W'(32767);
            r_x_bins   <= BIN_W'(MAX_BINS);
            r_y_min    <= '0;
            r_y_max    <= SAMPLE_W'(32767);
            r_y_bins   <= BIN_W'(MAX_BINS);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:   r_two_axis <= pwdata[0];
                REG_X_MIN:  r_x_min    <= pwdata[SAMPLE_W-1:0];
                REG_X_MAX:  r_x_max    <= pwdata[SAMPLE_W-1:0];
                REG_X_BINS: r_x_bins   <= pwdata[BIN_W-1:0];
                REG_Y_MIN:  r_y_min    <= pwdata[SAMPLE_W-1:0];
                REG_Y_MAX:  r_y_max    <= pwdata[SAMPLE_W-1:0];
                REG_Y_BINS: r_y_bins   <= pwdata[BIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_MODE:   prdata = {31'b0, r_two_axis};
            REG_X_MIN:  prdata = {16'b0, r_x_min};
            REG_X_MAX:  prdata = {16'b0, r_x_max};
            REG_X_BINS: prdata = {26'b0, r_x_bins};
            REG_Y_MIN:  prdata = {16'b0, r_y_min};
            REG_Y_MAX:  prdata = {16'b0, r_y_max};
            REG_Y_BINS: prdata = {26'b0, r_y_bins};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer registers ----------------
    t_state                     r_state;
    logic [ADDR_W-1:0]          r_clr_addr;
    t_in_item                   r_item;
    logic                       r_axis;      // 0 = x pass, 1 = y pass
    logic [SAMPLE_W-1:0]        r_d;         // v - min, known positive here
    logic [SAMPLE_W-1:0]        r_span;      // max - min, known positive here
    logic [DIVD_W-1:0]          r_rem;       // divider partial remainder
    logic [BIN_W-1:0]           r_q;         // divider quotient bits
    logic [2:0]                 r_step;      // quotient bit being resolved
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          r_sx;
    logic [ADDR_W-1:0]          r_addr;
    logic [COUNT_BITS-1:0]      r_rdata;
    logic [TOTAL_W-1:0]         r_total;
    logic                       r_out_valid;
    t_out_item                  r_out;

    // ---------------- axis front end (compare / subtract) ----------------
    logic signed [SAMPLE_W-1:0] ax_v, ax_lo, ax_hi;
    logic [BIN_W-1:0]           ax_n;
    logic signed [SAMPLE_W:0]   ax_d, ax_span;
    logic                       ax_under, ax_over, ax_trivial;

    always_comb begin
        ax_v  = r_axis ? r_item.y_sample : r_item.x_sample;
        ax_lo = r_axis ? r_y_min : r_x_min;
        ax_hi = r_axis ? r_y_max : r_x_max;
        ax_n  = eff_bins(r_axis ? r_y_bins : r_x_bins);
        ax_d     = {ax_v[SAMPLE_W-1], ax_v} - {ax_lo[SAMPLE_W-1], ax_lo};
        ax_span  = {ax_hi[SAMPLE_W-1], ax_hi} - {ax_lo[SAMPLE_W-1], ax_lo};
        ax_under = ax_v < ax_lo;
        ax_over  = ax_v > ax_hi;
        // empty/reversed range or sample on the low edge: slot 1
        ax_trivial = ax_span[SAMPLE_W] || (ax_span == '0) || (ax_d == '0);
    end

    // ---------------- shared divider step ----------------
    logic [DIVD_W:0]   div_trial;
    logic              div_take;
    logic [BIN_W-1:0]  div_q;

    always_comb begin
        div_trial = {1'b0, r_rem} - ((DIVD_W+1)'(r_span) << r_step);
        div_take  = !div_trial[DIVD_W];
        div_q     = r_q;
        if (div_take) begin
            div_q[r_step] = 1'b1;
        end
    end

    // ---------------- count update ----------------
    logic                   upd_sat;
    logic [COUNT_BITS-1:0]  upd_count;
    logic                   upd_go;
    logic                   upd_fill;
    logic [ADDR_W-1:0]      addr2d;

    assign upd_sat   = (r_rdata == COUNT_MAX);
    assign upd_fill  = (r_item.action == ACT_FILL);
    assign upd_count = (upd_fill && !upd_sat) ? r_rdata + COUNT_BITS'(1) : r_rdata;
    assign upd_go    = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    // x slot + (x bins + 2) * y slot; at most 4095 for legal bins
    assign addr2d = ADDR_W'(r_sx) +
                    ADDR_W'((SLOT_W+1)'(eff_bins(r_x_bins)) + (SLOT_W+1)'(2)) * ADDR_W'(r_slot);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
        end else begin
            // a new result replaces the old one on the edge it transfers
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_axis <= 1'b0;
                        if (i_in_data.action == ACT_READ) begin
                            r_addr  <= i_in_data.read_address;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    r_d    <= ax_d[SAMPLE_W-1:0];
                    r_span <= ax_span[SAMPLE_W-1:0];
                    if (ax_under) begin
                        r_slot  <= '0;
                        r_state <= S_SAVE;
                    end else if (ax_over) begin
                        r_slot  <= SLOT_W'(ax_n) + SLOT_W'(1);
                        r_state <= S_SAVE;
                    end else if (ax_trivial) begin
                        r_slot  <= SLOT_W'(1);
                        r_state <= S_SAVE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // dividend d*n - 1; quotient below n, so 6 steps suffice
                    r_rem   <= DIVD_W'(r_d * ax_n) - DIVD_W'(1);
                    r_q     <= '0;
                    r_step  <= 3'(BIN_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_take) begin
                        r_rem <= div_trial[DIVD_W-1:0];
                    end
                    r_q    <= div_q;
                    r_step <= r_step - 3'd1;
                    if (r_step == '0) begin
                        r_slot  <= SLOT_W'(div_q) + SLOT_W'(1);
                        r_state <= S_SAVE;
                    end
                end
                S_SAVE: begin
                    if (!r_axis) begin
                        r_sx <= r_slot;
                        if (r_two_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_CMP;
                        end else begin
                            r_addr  <= ADDR_W'(r_slot);
                            r_state <= S_READ;
                        end
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr  <= addr2d;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_go) begin
                        r_out.slot_address          <= r_addr;
                        r_out.slot_count            <= upd_count[31:0];
                        r_out.count_saturated       <= upd_sat;
                        if (upd_fill && (r_total != TOTAL_MAX)) begin
                            r_total                 <= r_total + TOTAL_W'(1);
                            r_out.total_entries     <= r_total + TOTAL_W'(1);
                        end else begin
                            r_out.total_entries     <= r_total;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- count store ----------------
    logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    assign mem_we    = (r_state == S_CLEAR) || (upd_go && upd_fill);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : upd_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    // a new result only comes out of the update step
    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_UPD)
        else $error("result valid raised outside update step");

    // total entry count never goes backward
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("total entry count decreased");

    // a fill always leaves a nonzero slot count
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && upd_fill) |=> (o_out_data.slot_count != '0))
        else $error("fill produced a zero slot count");

    // no transfer accepted while the store is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !(r_state == S_CMP || r_state == S_READ))
        else $error("item started during clearing pass");

endmodule

/* test/histogram_bin_filler_2d_test.sv */
// Self-checking testbench for the 2D equal-width histogram bin filler.
`timescale 1ns / 1ps

module histogram_bin_filler_2d_test;
    import hbf2d_pkg::*;

    localparam int          CLK_HALF_NS   = 6;
    localparam int          LIMIT_NS      = 12_000_000;
    localparam logic [2:0]  REG_SPARE     = 3'd7;         // index past the register list
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 72;
    localparam int          LONG_HOLD     = 400;

    // ---------------------------------------------------------------
    // DUT inputs start at known values; outputs come in on wires
    // ---------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               i_out_ready = 1'b1;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [31:0]        pwdata      = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    histogram_bin_filler_2d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Mirror of the block: register copies, slot counts, fill total
    // ---------------------------------------------------------------
    logic                  cfg_two_axis = 1'b0;
    int                    cfg_x_min    = 0;
    int                    cfg_x_max    = 32767;
    logic [BIN_W-1:0]      cfg_x_bins   = BIN_W'(62);
    int                    cfg_y_min    = 0;
    int                    cfg_y_max    = 32767;
    logic [BIN_W-1:0]      cfg_y_bins   = BIN_W'(62);
    logic [COUNT_BITS-1:0] slot_tally [STORE_DEPTH];
    logic [TOTAL_W-1:0]    fill_tally   = '0;

    // stimulus and scoreboard
    t_in_item   waiting_items [$];
    t_out_item  predicted_slots [$];
    int         items_queued  = 0;
    int         items_taken   = 0;
    int         results_seen  = 0;
    int         fills_taken   = 0;
    int         reads_taken   = 0;
    int         settings_used = 0;
    int         mismatches    = 0;
    logic       in_took       = 1'b0;

    // sender and receiver pacing
    int          burst_left     = 1;
    int          gap_left       = 0;
    int          hold_left      = 0;
    int          holds_done     = 0;
    logic        long_hold_done = 1'b0;
    logic [15:0] stall_bits     = '1;
    int          pat_pos        = 0;

    // register value 0 bins behaves as one bin, anything past MAX_BINS as MAX_BINS
    function automatic int usable_bins(logic [BIN_W-1:0] b);
        if (b == '0) return 1;
        if (int'(b) > MAX_BINS) return MAX_BINS;
        return int'(b);
    endfunction

    // Slot on one axis: 0 underflow, n+1 overflow, else 1 + lowest bin whose
    // upper edge reaches the sample (edge samples fall to the lower bin).
    function automatic int slot_on_axis(int v, int lo, int hi, int n);
        longint d;
        longint span;
        if (v < lo) return 0;
        if (v > hi) return n + 1;
        d    = longint'(v) - lo;
        span = longint'(hi) - lo;
        if (span <= 0 || d == 0) return 1;
        return int'((d * n - 1) / span) + 1;
    endfunction

    // Apply one item to the mirror and return the result it must produce.
    function automatic t_out_item tally_item(t_in_item it);
        t_out_item             r;
        int                    nx;
        int                    a;
        logic [COUNT_BITS-1:0] c;
        logic                  sat;
        if (it.action == ACT_READ) begin
            r.slot_address = it.read_address;
            c   = slot_tally[it.read_address];
            sat = (c == COUNT_MAX);
        end else begin
            nx = usable_bins(cfg_x_bins);
            a  = slot_on_axis(int'($signed(it.x_sample)), cfg_x_min, cfg_x_max, nx);
            if (cfg_two_axis) begin
                a = a + (nx + 2) * slot_on_axis(int'($signed(it.y_sample)), cfg_y_min,
                                                cfg_y_max, usable_bins(cfg_y_bins));
            end
            r.slot_address = a[ADDR_W-1:0];
            c   = slot_tally[r.slot_address];
            sat = (c == COUNT_MAX);
            if (!sat) c = c + 1'b1;
            slot_tally[r.slot_address] = c;
            if (fill_tally != TOTAL_MAX) fill_tally = fill_tally + 1'b1;
        end
        r.slot_count      = c[31:0];
        r.total_entries   = fill_tally;
        r.count_saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int any_sample();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Sample biased toward the axis range, its ends and the bin edges
    function automatic int pick_sample(int lo, int hi, int n);
        int a;
        int b;
        int k;
        int v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0: begin
                v = any_sample();
            end
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = lo - 1;
                    1:       v = lo;
                    2:       v = hi;
                    default: v = hi + 1;
                endcase
            end
            2, 3: begin
                k = int'($urandom_range(0, n));
                v = lo + (k * (hi - lo)) / n + int'($urandom_range(0, 2)) - 1;
            end
            default: begin
                v = a + int'($urandom_range(0, b - a));
            end
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       slots;
        it.action       = ACT_FILL;
        it.x_sample     = SAMPLE_W'(any_sample());
        it.y_sample     = SAMPLE_W'(any_sample());
        it.read_address = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
        if ($urandom_range(0, 3) == 0) begin
            it.action = ACT_READ;
            // mostly read inside the slots the current setting can fill
            if ($urandom_range(0, 4) != 0) begin
                slots = usable_bins(cfg_x_bins) + 2;
                if (cfg_two_axis) slots = slots * (usable_bins(cfg_y_bins) + 2);
                it.read_address = ADDR_W'($urandom_range(0, slots - 1));
            end
        end else begin
            it.x_sample = SAMPLE_W'(pick_sample(cfg_x_min, cfg_x_max, usable_bins(cfg_x_bins)));
            it.y_sample = SAMPLE_W'(pick_sample(cfg_y_min, cfg_y_max, usable_bins(cfg_y_bins)));
        end
        return it;
    endfunction

    task automatic offer(t_in_item it);
        waiting_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_fill(int x, int y);
        t_in_item it;
        it.action       = ACT_FILL;
        it.x_sample     = SAMPLE_W'(x);
        it.y_sample     = SAMPLE_W'(y);
        it.read_address = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
        offer(it);
    endtask

    task automatic queue_read(int addr);
        t_in_item it;
        it.action       = ACT_READ;
        it.x_sample     = SAMPLE_W'(any_sample());
        it.y_sample     = SAMPLE_W'(any_sample());
        it.read_address = ADDR_W'(addr);
        offer(it);
    endtask

    // Random axis: mostly well formed with assorted spans, some empty or reversed
    task automatic pick_range(output int lo, output int hi);
        int span;
        case ($urandom_range(0, 9))
            0: begin
                lo = any_sample();
                hi = lo;
            end
            1: begin
                span = int'($urandom_range(1, 2000));
                hi   = -32768 + int'($urandom_range(0, 65535 - span));
                lo   = hi + span;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       span = int'($urandom_range(1, 40));
                    1:       span = int'($urandom_range(41, 3000));
                    default: span = int'($urandom_range(3001, 65535));
                endcase
                lo = -32768 + int'($urandom_range(0, 65535 - span));
                hi = lo + span;
            end
        endcase
    endtask

    // APB write: setup cycle, access cycle, register lands on the edge with
    // psel/penable/pwrite/pready all high. Starts and ends on a falling edge.
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:   cfg_two_axis = value[0];
            REG_X_MIN:  cfg_x_min    = int'($signed(value[15:0]));
            REG_X_MAX:  cfg_x_max    = int'($signed(value[15:0]));
            REG_X_BINS: cfg_x_bins   = value[BIN_W-1:0];
            REG_Y_MIN:  cfg_y_min    = int'($signed(value[15:0]));
            REG_Y_MAX:  cfg_y_max    = int'($signed(value[15:0]));
            REG_Y_BINS: cfg_y_bins   = value[BIN_W-1:0];
            default:    ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_ranges(logic mode, int xlo, int xhi, int xb, int ylo, int yhi, int yb);
        reg_write(REG_MODE,   32'(mode));
        reg_write(REG_X_MIN,  32'(xlo));
        reg_write(REG_X_MAX,  32'(xhi));
        reg_write(REG_X_BINS, 32'(xb));
        reg_write(REG_Y_MIN,  32'(ylo));
        reg_write(REG_Y_MAX,  32'(yhi));
        reg_write(REG_Y_BINS, 32'(yb));
        settings_used++;
    endtask

    // Every queued item taken and answered; every item yields a result,
    // so the block is idle once the last one is back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_taken != items_queued || predicted_slots.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (waiting_items.size() > 0) begin
                i_in_data  <= waiting_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    // back-to-back stretch, no idling
                    burst_left = int'($urandom_range(30, 60));
                    gap_left   = 0;
                end else begin
                    burst_left = int'($urandom_range(1, 8));
                    gap_left   = int'($urandom_range(0, 25));
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: rotating 16-bit ready pattern, occasional holds, and one
    // long hold that backs the block up until it stops taking input
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left == 0 && !long_hold_done && items_taken >= 100) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
            holds_done++;
        end else if (hold_left == 0 && $urandom_range(0, 399) == 0) begin
            hold_left = int'($urandom_range(20, 80));
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= stall_bits[pat_pos];
            if (pat_pos == 15) begin
                pat_pos    = 0;
                stall_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            end else begin
                pat_pos++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input transfers, check on output transfers
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        in_took = i_rst_n && i_in_valid && o_in_ready;
        if (in_took) begin
            predicted_slots.push_back(tally_item(i_in_data));
            items_taken++;
            if (i_in_data.action == ACT_READ) reads_taken++;
            else fills_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (predicted_slots.size() == 0) begin
                report_mismatch("result with nothing expected, slot",
                                32'(o_out_data.slot_address), 32'd0);
            end else begin
                want = predicted_slots.pop_front();
                if (o_out_data.slot_address !== want.slot_address)
                    report_mismatch("slot_address", 32'(o_out_data.slot_address),
                                    32'(want.slot_address));
                if (o_out_data.slot_count !== want.slot_count)
                    report_mismatch("slot_count", o_out_data.slot_count, want.slot_count);
                if (o_out_data.total_entries !== want.total_entries)
                    report_mismatch("total_entries", o_out_data.total_entries,
                                    want.total_entries);
                if (o_out_data.count_saturated !== want.count_saturated)
                    report_mismatch("count_saturated", 32'(o_out_data.count_saturated),
                                    32'(want.count_saturated));
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int xlo;
        int xhi;
        int ylo;
        int yhi;
        for (int i = 0; i < STORE_DEPTH; i++) slot_tally[i] = '0;

        // sync reset held low, then released; the block then clears its store on its own
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: 1D, x 0..32767, 62 bins. Both ends, just outside,
        // and reads at the low slots, the overflow slot and the top address.
        queue_fill(-32768, 32767);
        queue_fill(-1, -32768);
        queue_fill(0, 0);
        queue_fill(1, -1);
        queue_fill(16384, 100);
        queue_fill(32767, 5);
        queue_fill(0, 0);
        queue_read(0);
        queue_read(1);
        queue_read(63);
        queue_read(4095);
        wait_drained();

        // 2D: x -100..100 in 4 bins (edges at -50, 0, 50), y full range
        load_ranges(1'b1, -100, 100, 4, -32768, 32767, 62);
        queue_fill(-50, -32768);
        queue_fill(0, 32767);
        queue_fill(101, 0);
        queue_fill(-101, -1);
        queue_fill(100, 1);
        queue_read(6);
        wait_drained();

        // Clamped bin counts (0 and 63), empty x range, reversed y range,
        // and a write to the unused index that must change nothing.
        load_ranges(1'b1, 5, 5, 0, 10, -10, 63);
        reg_write(REG_SPARE, 32'hFFFF_FFFF);
        queue_fill(5, 9);
        queue_fill(4, 10);
        queue_fill(6, -20);
        queue_fill(5, 10);
        queue_fill(5, 11);
        queue_read(1);
        wait_drained();

        // Random phases: widest 2D store first, then a single-bin x axis with a narrow
        // y range, then random settings including empty and reversed ranges.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    load_ranges(1'b1, -32768, 32767, 62, -32768, 32767, 62);
                end
                1: begin
                    load_ranges(1'b1, -32768, 32767, 1, 32766, 32767, 63);
                end
                default: begin
                    pick_range(xlo, xhi);
                    pick_range(ylo, yhi);
                    load_ranges(1'($urandom_range(0, 1)), xlo, xhi,
                                int'($urandom_range(0, 63)), ylo, yhi,
                                int'($urandom_range(0, 63)));
                end
            endcase
            repeat (PHASE_ITEMS) offer(random_item());
            wait_drained();
        end

        // trailing window for any stray result
        repeat (40) @(negedge i_clk);
        if (predicted_slots.size() != 0)
            report_mismatch("results never delivered", 32'(predicted_slots.size()), 32'd0);

        $display("covered %0d fills and %0d reads over %0d axis settings (full, single-bin,",
                 fills_taken, reads_taken, settings_used);
        $display("empty and reversed ranges), %0d receiver holds, %0d results checked",
                 holds_done, results_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("timeout after %0d ns", LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hbf2d_pkg.sv
rtl/core/histogram_bin_filler_2d.sv
test/histogram_bin_filler_2d_test.sv
